FILE: rtl/core/lsca_pkg.sv
// ----------------------------------------------------------------------------
// lsca_pkg
// Shared types, constants and helpers of the Lorentz-shift chi-square block.
// ----------------------------------------------------------------------------
package lsca_pkg;

  // Reset value of the tangent-per-tesla register, signed Q1.15 (about 0.08).
  localparam logic signed [15:0] TanPerTeslaReset = 16'sd2621;

  // Saturation value of the Q32.16 running sum.
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  // The constant 1.0 at the Q.54 scale of the denominator.
  localparam logic [60:0] DenOne = {7'd1, 54'd0};

  // Quotient bits produced by the divider for each kind of division.
  localparam logic [5:0] DivStepsTan = 6'd23;
  localparam logic [5:0] DivStepsChi = 6'd48;

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic signed [23:0] meas_shift_x;
    logic signed [23:0] meas_shift_y;
    logic [23:0]        sigma_x;
    logic [23:0]        sigma_y;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] mcand;
    logic [31:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [60:0] rem_init;
    logic [60:0] divisor;
    logic [47:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [47:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        add;
    logic        force_sat;
    logic        zero_seen;
    logic        clear;
    logic [47:0] term;
  } acc_cmd_t;

  typedef struct packed {
    logic [47:0] sum;
    logic        zero_seen;
    logic        saturated;
  } acc_sts_t;

  // Magnitude of a signed 16-bit value; the most negative value maps to 32768.
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] raw;
    raw = v;
    return v[15] ? 16'(~raw + 16'd1) : raw;
  endfunction

endpackage

FILE: rtl/core/lsca_ser_mul.sv
// ----------------------------------------------------------------------------
// lsca_ser_mul
// Unsigned 32x32 shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lsca_ser_mul import lsca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] mcand_q;
  logic [63:0] prod_q;
  logic [32:0] psum;

  // The upper half collects partial products while the multiplier shifts out below.
  assign psum = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, mcand_q} : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
      prod_q  <= {32'd0, req_i.mplier};
    end else if (busy_q) begin
      prod_q <= {psum, prod_q[31:1]};
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.product = prod_q;

endmodule

FILE: rtl/core/lsca_ser_div.sv
// ----------------------------------------------------------------------------
// lsca_ser_div
// Restoring radix-2 divider, one quotient bit per cycle, up to 48 bits.
// ----------------------------------------------------------------------------
module lsca_ser_div import lsca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [60:0] rem_q;
  logic [60:0] dsr_q;
  logic [47:0] dvd_q;
  logic [47:0] quo_q;
  logic [61:0] trial;
  logic [62:0] sub;
  logic        ge;

  // The partial remainder always stays below the divisor, so it fits 61 bits.
  assign trial = {rem_q, dvd_q[47]};
  assign sub   = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~sub[62];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps - 6'd1;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      dsr_q <= req_i.divisor;
      dvd_q <= req_i.dividend;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? sub[60:0] : trial[60:0];
      quo_q <= {quo_q[46:0], ge};
      dvd_q <= {dvd_q[46:0], 1'b0};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/core/lsca_accum.sv
// ----------------------------------------------------------------------------
// lsca_accum
// Saturating Q32.16 running sum with the zero-sigma and saturation flags.
// ----------------------------------------------------------------------------
module lsca_accum import lsca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  acc_cmd_t cmd_i,
  output acc_sts_t sts_o
);

  logic [47:0] sum_q;
  logic        zero_q;
  logic        sat_q;
  logic [48:0] total;

  assign total = {1'b0, sum_q} + {1'b0, cmd_i.term};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      zero_q <= 1'b0;
      sat_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      sum_q  <= '0;
      zero_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      if (cmd_i.force_sat) begin
        sum_q <= SumMax;
        sat_q <= 1'b1;
      end else if (cmd_i.add) begin
        // A carry out of the sum means it passed the largest Q32.16 value.
        if (total[48]) begin
          sum_q <= SumMax;
          sat_q <= 1'b1;
        end else begin
          sum_q <= total[47:0];
        end
      end
      if (cmd_i.zero_seen) begin
        zero_q <= 1'b1;
      end
    end
  end

  assign sts_o.sum       = sum_q;
  assign sts_o.zero_seen = zero_q;
  assign sts_o.saturated = sat_q;

endmodule

FILE: rtl/core/lsca_ctrl.sv
// ----------------------------------------------------------------------------
// lsca_ctrl
// Sequencer that steps one measurement through the shared multiplier and
// divider, first for the x axis and then for the y axis.
// ----------------------------------------------------------------------------
module lsca_ctrl import lsca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               item_valid_i,
  input  logic signed [15:0] tan_per_tesla_i,
  input  logic               out_ready_i,
  input  mul_rsp_t           mul_rsp_i,
  input  div_rsp_t           div_rsp_i,
  output mul_req_t           mul_req_o,
  output div_req_t           div_req_o,
  output acc_cmd_t           acc_cmd_o,
  output logic               item_done_o,
  output logic               out_load_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StP2   = 4'd1;
  localparam logic [3:0] StBz2  = 4'd2;
  localparam logic [3:0] StDen  = 4'd3;
  localparam logic [3:0] StTa   = 4'd4;
  localparam logic [3:0] StBb   = 4'd5;
  localparam logic [3:0] StTb   = 4'd6;
  localparam logic [3:0] StTdiv = 4'd7;
  localparam logic [3:0] StN2   = 4'd8;
  localparam logic [3:0] StD2   = 4'd9;
  localparam logic [3:0] StTerm = 4'd10;
  localparam logic [3:0] StFin  = 4'd11;

  logic [3:0]  state_q, state_d;
  logic        wait_q, wait_d;
  logic        axis_q, axis_d;

  logic [30:0] p2_q;
  logic [30:0] bz2_q;
  logic [60:0] den_q;
  logic [62:0] num_q;
  logic [30:0] bb_q;
  logic [24:0] diff_q;
  logic [47:0] n2_q;
  logic [47:0] d2_q;

  logic [15:0] ap, ax, ay, az;
  logic        ta_neg, tb_neg;
  logic [23:0] shift_sel;
  logic [23:0] sigma_sel;
  logic [62:0] ta_ext, tb_ext, num_abs;
  logic [24:0] tq, tan_s, diff_val, diff_abs_full;
  logic [23:0] diff_abs;
  logic        ovf;
  logic        mul_done;
  logic        div_done;
  logic        mul_op;
  logic [3:0]  mul_next;

  assign ap = mag16(tan_per_tesla_i);
  assign ax = mag16(item_i.field_x);
  assign ay = mag16(item_i.field_y);
  assign az = mag16(item_i.field_z);

  // The x numerator is p*By*2^27 + p^2*Bx*Bz and the y numerator is
  // p^2*By*Bz - p*Bx*2^27; products run on magnitudes and the signs ride along.
  assign ta_neg = axis_q ? ~(tan_per_tesla_i[15] ^ item_i.field_x[15])
                         : (tan_per_tesla_i[15] ^ item_i.field_y[15]);
  assign tb_neg = axis_q ? (item_i.field_y[15] ^ item_i.field_z[15])
                         : (item_i.field_x[15] ^ item_i.field_z[15]);

  assign shift_sel = axis_q ? item_i.meas_shift_y : item_i.meas_shift_x;
  assign sigma_sel = axis_q ? item_i.sigma_y : item_i.sigma_x;

  assign ta_ext  = {5'd0, mul_rsp_i.product[30:0], 27'd0};
  assign tb_ext  = {2'd0, mul_rsp_i.product[60:0]};
  assign num_abs = num_q[62] ? (~num_q + 63'd1) : num_q;

  // The tangent is truncated toward zero, so its sign is applied after the divide.
  assign tq            = {2'd0, div_rsp_i.quotient[22:0]};
  assign tan_s         = num_q[62] ? (~tq + 25'd1) : tq;
  assign diff_val      = tan_s - {shift_sel[23], shift_sel};
  assign diff_abs_full = diff_q[24] ? (~diff_q + 25'd1) : diff_q;
  assign diff_abs      = diff_abs_full[23:0];

  // The term reaches 2^48 exactly when diff^2 >= sigma^2 * 2^32.
  assign ovf = (d2_q[47:16] == 32'd0) && (n2_q >= {d2_q[15:0], 32'd0});

  assign mul_done = wait_q && !mul_rsp_i.busy;
  assign div_done = wait_q && !div_rsp_i.busy;

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    axis_d      = axis_q;
    mul_req_o   = '0;
    div_req_o   = '0;
    acc_cmd_o   = '0;
    item_done_o = 1'b0;
    out_load_o  = 1'b0;
    mul_op      = 1'b0;
    mul_next    = StIdle;

    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          state_d = StP2;
          wait_d  = 1'b0;
          axis_d  = 1'b0;
        end
      end
      StP2: begin
        mul_op           = 1'b1;
        mul_next         = StBz2;
        mul_req_o.mcand  = {16'd0, ap};
        mul_req_o.mplier = {16'd0, ap};
      end
      StBz2: begin
        mul_op           = 1'b1;
        mul_next         = StDen;
        mul_req_o.mcand  = {16'd0, az};
        mul_req_o.mplier = {16'd0, az};
      end
      StDen: begin
        mul_op           = 1'b1;
        mul_next         = StTa;
        mul_req_o.mcand  = {1'b0, p2_q};
        mul_req_o.mplier = {1'b0, bz2_q};
      end
      StTa: begin
        mul_op           = 1'b1;
        mul_next         = StBb;
        mul_req_o.mcand  = {16'd0, ap};
        mul_req_o.mplier = {16'd0, (axis_q ? ax : ay)};
      end
      StBb: begin
        mul_op           = 1'b1;
        mul_next         = StTb;
        mul_req_o.mcand  = {16'd0, (axis_q ? ay : ax)};
        mul_req_o.mplier = {16'd0, az};
      end
      StTb: begin
        mul_op           = 1'b1;
        mul_next         = StTdiv;
        mul_req_o.mcand  = {1'b0, p2_q};
        mul_req_o.mplier = {1'b0, bb_q};
      end
      StTdiv: begin
        div_req_o.steps    = DivStepsTan;
        div_req_o.rem_init = {7'd0, num_abs[60:7]};
        div_req_o.divisor  = den_q;
        div_req_o.dividend = {num_abs[6:0], 41'd0};
        if (!wait_q) begin
          div_req_o.start = 1'b1;
          wait_d          = 1'b1;
        end else if (!div_rsp_i.busy) begin
          wait_d  = 1'b0;
          state_d = StN2;
        end
      end
      StN2: begin
        mul_op           = 1'b1;
        mul_next         = StD2;
        mul_req_o.mcand  = {8'd0, diff_abs};
        mul_req_o.mplier = {8'd0, diff_abs};
      end
      StD2: begin
        mul_op           = 1'b1;
        mul_next         = StTerm;
        mul_req_o.mcand  = {8'd0, sigma_sel};
        mul_req_o.mplier = {8'd0, sigma_sel};
      end
      StTerm: begin
        div_req_o.steps    = DivStepsChi;
        div_req_o.rem_init = {45'd0, n2_q[47:32]};
        div_req_o.divisor  = {13'd0, d2_q};
        div_req_o.dividend = {n2_q[31:0], 16'd0};
        acc_cmd_o.term     = div_rsp_i.quotient;
        if (sigma_sel == 24'd0) begin
          acc_cmd_o.zero_seen = 1'b1;
          state_d             = axis_q ? StFin : StTa;
          axis_d              = 1'b1;
        end else if (ovf) begin
          acc_cmd_o.force_sat = 1'b1;
          state_d             = axis_q ? StFin : StTa;
          axis_d              = 1'b1;
        end else if (!wait_q) begin
          div_req_o.start = 1'b1;
          wait_d          = 1'b1;
        end else if (!div_rsp_i.busy) begin
          acc_cmd_o.add = 1'b1;
          wait_d        = 1'b0;
          state_d       = axis_q ? StFin : StTa;
          axis_d        = 1'b1;
        end
      end
      StFin: begin
        if (!item_i.last_item) begin
          item_done_o = 1'b1;
          state_d     = StIdle;
        end else if (out_ready_i) begin
          item_done_o     = 1'b1;
          out_load_o      = 1'b1;
          acc_cmd_o.clear = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        wait_d  = 1'b0;
      end
    endcase

    // Every multiply state issues once and then waits for the unit to finish.
    if (mul_op) begin
      if (!wait_q) begin
        mul_req_o.start = 1'b1;
        wait_d          = 1'b1;
      end else if (!mul_rsp_i.busy) begin
        wait_d  = 1'b0;
        state_d = mul_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wait_q  <= 1'b0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StP2: begin
        if (mul_done) p2_q <= mul_rsp_i.product[30:0];
      end
      StBz2: begin
        if (mul_done) bz2_q <= mul_rsp_i.product[30:0];
      end
      StDen: begin
        if (mul_done) den_q <= DenOne + mul_rsp_i.product[60:0];
      end
      StTa: begin
        if (mul_done) num_q <= ta_neg ? (~ta_ext + 63'd1) : ta_ext;
      end
      StBb: begin
        if (mul_done) bb_q <= mul_rsp_i.product[30:0];
      end
      StTb: begin
        if (mul_done) num_q <= tb_neg ? (num_q - tb_ext) : (num_q + tb_ext);
      end
      StTdiv: begin
        if (div_done) diff_q <= diff_val;
      end
      StN2: begin
        if (mul_done) n2_q <= mul_rsp_i.product[47:0];
      end
      StD2: begin
        if (mul_done) d2_q <= mul_rsp_i.product[47:0];
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/lorentz_shift_chi2_accumulator.sv
// ----------------------------------------------------------------------------
// lorentz_shift_chi2_accumulator
// Accumulates the chi-square of predicted against measured Lorentz shifts.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_we_i                cfg_wdata_i (tan per tesla)
//   in        in         in_valid_i / in_stall_o measurement fields, last_item_i
//   out       out        out_valid_o/out_stall_i chi2_total_o and two flags
//
// A measurement occupies the block from one transaction to the next; an axis
// whose uncertainty is zero or whose term overflows skips its term divide. The
// time is set by one bit-serial multiplier (13 products) and one radix-2 divider
// (one divide per tangent and one per term). Reset clears the running sum, its
// flags and both handshakes and restores the register, but not the output. The
// input stalls while a measurement is in work; a finished sum waits in the output
// register, and the block holds a final item only while it is full and stalled.
// ----------------------------------------------------------------------------
module lorentz_shift_chi2_accumulator import lsca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] field_x_i,
  input  logic signed [15:0] field_y_i,
  input  logic signed [15:0] field_z_i,
  input  logic signed [23:0] meas_shift_x_i,
  input  logic signed [23:0] meas_shift_y_i,
  input  logic [23:0]        sigma_x_i,
  input  logic [23:0]        sigma_y_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        chi2_total_o,
  output logic               zero_sigma_seen_o,
  output logic               sum_saturated_o
);

  logic signed [15:0] tan_q;
  item_t              item_q;
  logic               buf_full_q;
  logic               accept;
  logic               out_valid_q;
  logic               out_ready;
  logic [47:0]        chi2_q;
  logic               zero_q;
  logic               sat_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  acc_cmd_t acc_cmd;
  acc_sts_t acc_sts;
  logic     item_done;
  logic     out_load;

  assign accept     = in_valid_i && !buf_full_q;
  assign in_stall_o = buf_full_q;
  assign out_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tan_q       <= TanPerTeslaReset;
      buf_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tan_q <= cfg_wdata_i;
      end
      if (accept) begin
        buf_full_q <= 1'b1;
      end else if (item_done) begin
        buf_full_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.field_x      <= field_x_i;
      item_q.field_y      <= field_y_i;
      item_q.field_z      <= field_z_i;
      item_q.meas_shift_x <= meas_shift_x_i;
      item_q.meas_shift_y <= meas_shift_y_i;
      item_q.sigma_x      <= sigma_x_i;
      item_q.sigma_y      <= sigma_y_i;
      item_q.last_item    <= last_item_i;
    end
    if (out_load) begin
      chi2_q <= acc_sts.sum;
      zero_q <= acc_sts.zero_seen;
      sat_q  <= acc_sts.saturated;
    end
  end

  lsca_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_q),
    .item_valid_i    (buf_full_q),
    .tan_per_tesla_i (tan_q),
    .out_ready_i     (out_ready),
    .mul_rsp_i       (mul_rsp),
    .div_rsp_i       (div_rsp),
    .mul_req_o       (mul_req),
    .div_req_o       (div_req),
    .acc_cmd_o       (acc_cmd),
    .item_done_o     (item_done),
    .out_load_o      (out_load)
  );

  lsca_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  lsca_ser_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lsca_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (acc_cmd),
    .sts_o  (acc_sts)
  );

  assign out_valid_o       = out_valid_q;
  assign chi2_total_o      = chi2_q;
  assign zero_sigma_seen_o = zero_q;
  assign sum_saturated_o   = sat_q;

  // A measurement can only finish while its fields are still held.
  a_done_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_done |-> buf_full_q)
    else $error("measurement finished without a held input");

  // A result is never written over one that has not been taken.
  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_ready)
    else $error("result loaded into a full output register");

  // The sequencer drives only one arithmetic unit at a time.
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy together");

  // After a transaction the input stays closed while that measurement is worked on.
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transaction");

endmodule
